// ===== rtl/core/ddmacr_pkg.sv =====
// ----------------------------------------------------------------------------
// ddmacr_pkg
// Widths, codes and port numbers shared by the dual DMA register block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package ddmacr_pkg;

    // Field widths of a request and a result
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned PORT_W   = 11;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CH_W     = 3;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned BASE_W   = 28;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned EB_W     = 2;

    localparam int unsigned NUM_CH   = 8;
    localparam int unsigned NUM_CHIP = 2;

    // Request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PORT_WR = 2'd0,
        OP_PORT_RD = 2'd1,
        OP_XFER    = 2'd2
    } t_opcode;

    // Fixed command and status ports, first and second chip
    localparam logic [PORT_W-1:0] PORT_STATUS0 = 11'h008;
    localparam logic [PORT_W-1:0] PORT_STATUS1 = 11'h0D0;
    localparam logic [PORT_W-1:0] PORT_SMASK0  = 11'h00A;
    localparam logic [PORT_W-1:0] PORT_SMASK1  = 11'h0D4;
    localparam logic [PORT_W-1:0] PORT_MODE0   = 11'h00B;
    localparam logic [PORT_W-1:0] PORT_MODE1   = 11'h0D6;
    localparam logic [PORT_W-1:0] PORT_FFCLR0  = 11'h00C;
    localparam logic [PORT_W-1:0] PORT_FFCLR1  = 11'h0D8;
    localparam logic [PORT_W-1:0] PORT_MRST0   = 11'h00D;
    localparam logic [PORT_W-1:0] PORT_MRST1   = 11'h0DA;
    localparam logic [PORT_W-1:0] PORT_MCLR0   = 11'h00E;
    localparam logic [PORT_W-1:0] PORT_MCLR1   = 11'h0DC;
    localparam logic [PORT_W-1:0] PORT_AMASK0  = 11'h00F;
    localparam logic [PORT_W-1:0] PORT_AMASK1  = 11'h0DE;

    // Upper port bits of the page register windows and the second-chip block
    localparam logic [6:0] PAGE_LO_BLK = 7'h08;
    localparam logic [6:0] PAGE_HI_BLK = 7'h48;
    localparam logic [6:0] CHIP1_BLK   = 7'h0C;

    // Mode byte fields
    localparam logic [1:0] OPMODE_SINGLE = 2'd1;
    localparam logic [1:0] TRMODE_ILLEGAL = 2'd3;

    // Result codes
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [EB_W-1:0]   EB_BYTE   = 2'd1;
    localparam logic [EB_W-1:0]   EB_WORD   = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PORT_W-1:0]   port;
        logic [DATA_W-1:0]   write_data;
        logic [CH_W-1:0]     channel;
        logic [LEN_W-1:0]    request_length;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [LEN_W-1:0]  moved_count;
        logic [ADDR_W-1:0] start_address;
        logic [KIND_W-1:0] transfer_kind;
        logic              address_decrements;
        logic [EB_W-1:0]   element_bytes;
        logic              terminal_count;
    } t_rsp;

endpackage

// ===== rtl/core/ddmacr_req_if.sv =====
// ----------------------------------------------------------------------------
// ddmacr_req_if
// Request channel: port write, port read or transfer request.
// ----------------------------------------------------------------------------
interface ddmacr_req_if;
    import ddmacr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PORT_W-1:0]   port;
    logic [DATA_W-1:0]   write_data;
    logic [CH_W-1:0]     channel;
    logic [LEN_W-1:0]    request_length;

    modport source (
        output valid, opcode, port, write_data, channel, request_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, port, write_data, channel, request_length,
        output ready
    );
endinterface

// ===== rtl/core/ddmacr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ddmacr_rsp_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface ddmacr_rsp_if;
    import ddmacr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  moved_count;
    logic [ADDR_W-1:0] start_address;
    logic [KIND_W-1:0] transfer_kind;
    logic              address_decrements;
    logic [EB_W-1:0]   element_bytes;
    logic              terminal_count;

    modport source (
        output valid, read_data, moved_count, start_address, transfer_kind,
               address_decrements, element_bytes, terminal_count,
        input  ready
    );
    modport sink (
        input  valid, read_data, moved_count, start_address, transfer_kind,
               address_decrements, element_bytes, terminal_count,
        output ready
    );
endinterface

// ===== rtl/core/dual_dma_controller_registers_core.sv =====
// ----------------------------------------------------------------------------
// dual_dma_controller_registers_core
// Register file of a cascaded pair of 8237-style DMA controllers.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: a port write, a port read or a transfer
//   request for a channel. o_rsp returns exactly one result per request,
//   in order. Both channels use valid/ready; a request moves when both are
//   high at a rising edge.
//   A request accepted into the input register is decoded there, and its
//   result is then loaded into the output register, which drives o_rsp;
//   the load waits while the output register holds a result not yet taken.
//   Throughput: one request per cycle while the receiver keeps taking
//   results, set by the single register-update stage between the input and
//   output registers.
//   When the receiver stalls, the output register holds its result and the
//   input register holds one more request; i_req.ready then drops.
//   Reset (synchronous, active low) empties both registers, zeroes the
//   address, count, mode and status registers, masks all eight channels
//   and points both byte flip-flops at the low byte.
// ----------------------------------------------------------------------------
module dual_dma_controller_registers_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ddmacr_req_if.sink    i_req,
    ddmacr_rsp_if.source  o_rsp
);
    import ddmacr_pkg::*;

    typedef struct packed {
        logic            vld;
        logic [CH_W-1:0] ch;
    } t_page_hit;

    // Page register low nibble to channel; channel 4 has no page register
    function automatic t_page_hit page_map(input logic [3:0] lo);
        t_page_hit h;
        h.vld = 1'b1;
        unique case (lo)
            4'h7:    h.ch = 3'd0;
            4'h3:    h.ch = 3'd1;
            4'h1:    h.ch = 3'd2;
            4'h2:    h.ch = 3'd3;
            4'hB:    h.ch = 3'd5;
            4'h9:    h.ch = 3'd6;
            4'hA:    h.ch = 3'd7;
            default: begin
                h.vld = 1'b0;
                h.ch  = 3'd0;
            end
        endcase
        return h;
    endfunction

    // Pipeline registers
    t_req  r_req;
    logic  r_req_vld;
    t_rsp  r_rsp;
    logic  r_rsp_vld;
    t_rsp  n_rsp;

    // Channel and chip state
    logic [BASE_W-1:0] r_base_addr [NUM_CH];
    logic [LEN_W-1:0]  r_base_cnt  [NUM_CH];
    logic [ADDR_W-1:0] r_cur_addr  [NUM_CH];
    logic [LEN_W-1:0]  r_cur_cnt   [NUM_CH];
    logic [7:0]        r_mode      [NUM_CH];
    logic [3:0]        r_mask      [NUM_CHIP];
    logic [7:0]        r_status    [NUM_CHIP];
    logic              r_tog       [NUM_CHIP];

    logic [BASE_W-1:0] n_base_addr [NUM_CH];
    logic [LEN_W-1:0]  n_base_cnt  [NUM_CH];
    logic [ADDR_W-1:0] n_cur_addr  [NUM_CH];
    logic [LEN_W-1:0]  n_cur_cnt   [NUM_CH];
    logic [7:0]        n_mode      [NUM_CH];
    logic [3:0]        n_mask      [NUM_CHIP];
    logic [7:0]        n_status    [NUM_CHIP];
    logic              n_tog       [NUM_CHIP];

    // Handshake
    logic acc;
    logic adv;

    assign adv         = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign i_req.ready = !r_req_vld || adv;
    assign acc         = i_req.valid && i_req.ready;

    // Port decode
    logic [PORT_W-1:0] p;
    logic [DATA_W-1:0] v;
    logic              addr_hit;
    logic              cnt_hit;
    logic [CH_W-1:0]   addr_ch;
    logic [CH_W-1:0]   cnt_ch;
    logic              page_lo_hit;
    logic              page_hi_hit;
    t_page_hit         pg;
    logic [CH_W-1:0]   sel;
    logic              chip;
    logic [1:0]        sub;

    assign p = r_req.port;
    assign v = r_req.write_data;

    always_comb begin
        addr_hit = 1'b0;
        addr_ch  = '0;
        cnt_hit  = 1'b0;
        cnt_ch   = '0;
        if (p[10:3] == 8'h00) begin
            addr_hit = !p[0];
            cnt_hit  = p[0];
            addr_ch  = {1'b0, p[2:1]};
            cnt_ch   = {1'b0, p[2:1]};
        end else if (p[10:4] == CHIP1_BLK) begin
            addr_hit = (p[1:0] == 2'd0);
            cnt_hit  = (p[1:0] == 2'd2);
            addr_ch  = {1'b1, p[3:2]};
            cnt_ch   = {1'b1, p[3:2]};
        end
    end

    assign page_lo_hit = (p[10:4] == PAGE_LO_BLK);
    assign page_hi_hit = (p[10:4] == PAGE_HI_BLK);
    assign pg          = page_map(p[3:0]);

    // One channel per request: the transfer's channel or the decoded port's
    always_comb begin
        if (r_req.opcode == OP_XFER) begin
            sel = r_req.channel;
        end else if (addr_hit) begin
            sel = addr_ch;
        end else if (cnt_hit) begin
            sel = cnt_ch;
        end else begin
            sel = pg.ch;
        end
    end

    assign chip = sel[2];
    assign sub  = sel[1:0];

    // Transfer arithmetic
    logic [7:0]        m;
    logic              down;
    logic              autoinit;
    logic              xfer_ok;
    logic [LEN_W-1:0]  cc;
    logic [ADDR_W-1:0] ca;
    logic [LEN_W-1:0]  n_elem;
    logic [LEN_W:0]    step;
    logic [ADDR_W-1:0] ca_next;
    logic [LEN_W-1:0]  cc_next;
    logic [7:0]        cnt_byte;

    assign m        = r_mode[sel];
    assign down     = m[5];
    assign autoinit = m[4];
    assign cc       = r_cur_cnt[sel];
    assign ca       = r_cur_addr[sel];
    assign xfer_ok  = !r_mask[chip][sub] && (m[7:6] == OPMODE_SINGLE)
                      && (m[3:2] != TRMODE_ILLEGAL);
    assign n_elem   = (cc < r_req.request_length) ? cc : r_req.request_length;
    assign step     = chip ? {n_elem, 1'b0} : {1'b0, n_elem};
    assign ca_next  = down ? (ca - ADDR_W'(step)) : (ca + ADDR_W'(step));
    assign cc_next  = cc - n_elem;
    assign cnt_byte = v + 8'd1;

    // Next state and result of the request in the input register
    always_comb begin
        n_base_addr = r_base_addr;
        n_base_cnt  = r_base_cnt;
        n_cur_addr  = r_cur_addr;
        n_cur_cnt   = r_cur_cnt;
        n_mode      = r_mode;
        n_mask      = r_mask;
        n_status    = r_status;
        n_tog       = r_tog;

        n_rsp                    = '0;
        n_rsp.element_bytes      = EB_BYTE;

        case (r_req.opcode)
            OP_PORT_WR: begin
                if (addr_hit) begin
                    if (!r_tog[chip]) begin
                        n_base_addr[sel][7:0] = v;
                    end else begin
                        n_base_addr[sel][15:8] = v;
                        n_cur_addr[sel] = ADDR_W'(n_base_addr[sel]);
                    end
                    n_tog[chip] = !r_tog[chip];
                end else if (cnt_hit) begin
                    if (!r_tog[chip]) begin
                        n_base_cnt[sel][7:0] = cnt_byte;
                    end else begin
                        n_base_cnt[sel][15:8] = cnt_byte;
                        n_cur_cnt[sel] = n_base_cnt[sel];
                    end
                    n_tog[chip] = !r_tog[chip];
                end else if (page_lo_hit) begin
                    if (pg.vld) begin
                        n_base_addr[sel][23:16] = v;
                    end
                end else if (page_hi_hit) begin
                    if (pg.vld) begin
                        n_base_addr[sel][27:24] = v[3:0];
                    end
                end else begin
                    unique case (p)
                        PORT_MODE0:  n_mode[{1'b0, v[1:0]}] = v;
                        PORT_MODE1:  n_mode[{1'b1, v[1:0]}] = v;
                        PORT_SMASK0: n_mask[0][v[1:0]] = v[2];
                        PORT_SMASK1: n_mask[1][v[1:0]] = v[2];
                        PORT_AMASK0: n_mask[0] = v[3:0];
                        PORT_AMASK1: n_mask[1] = v[3:0];
                        PORT_FFCLR0: n_tog[0] = 1'b0;
                        PORT_FFCLR1: n_tog[1] = 1'b0;
                        PORT_MRST0: begin
                            n_tog[0]  = 1'b0;
                            n_mask[0] = 4'hF;
                        end
                        PORT_MRST1: begin
                            n_tog[1]  = 1'b0;
                            n_mask[1] = 4'hF;
                        end
                        PORT_MCLR0:  n_mask[0] = 4'h0;
                        PORT_MCLR1:  n_mask[1] = 4'h0;
                        default: ;
                    endcase
                end
            end

            OP_PORT_RD: begin
                if (addr_hit) begin
                    n_rsp.read_data = r_tog[chip] ? ca[15:8] : ca[7:0];
                    n_tog[chip]     = !r_tog[chip];
                end else if (cnt_hit) begin
                    n_rsp.read_data = r_tog[chip] ? cc[15:8] : cc[7:0];
                    n_tog[chip]     = !r_tog[chip];
                end else if (page_lo_hit) begin
                    n_rsp.read_data = pg.vld ? r_base_addr[sel][23:16] : 8'h00;
                end else if (page_hi_hit) begin
                    n_rsp.read_data = pg.vld ? {4'h0, r_base_addr[sel][27:24]} : 8'h00;
                end else if (p == PORT_STATUS0) begin
                    n_rsp.read_data = r_status[0];
                end else if (p == PORT_STATUS1) begin
                    n_rsp.read_data = r_status[1];
                end
            end

            OP_XFER: begin
                n_rsp.element_bytes = chip ? EB_WORD : EB_BYTE;
                if (xfer_ok) begin
                    n_rsp.start_address      = ca;
                    n_rsp.moved_count        = n_elem;
                    n_rsp.transfer_kind      = m[3:2] + 2'd1;
                    n_rsp.address_decrements = down;
                    n_cur_cnt[sel]           = cc_next;
                    n_cur_addr[sel]          = ca_next;
                    // Terminal count: flag it, drop the request bit, reload if auto-init is set
                    if (cc_next == '0) begin
                        n_rsp.terminal_count          = 1'b1;
                        n_status[chip][{1'b0, sub}]   = 1'b1;
                        n_status[chip][{1'b1, sub}]   = 1'b0;
                        if (autoinit) begin
                            n_cur_addr[sel] = ADDR_W'(r_base_addr[sel]);
                            n_cur_cnt[sel]  = r_base_cnt[sel];
                        end
                    end
                end
            end

            default: ;
        endcase
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req.opcode         <= i_req.opcode;
            r_req.port           <= i_req.port;
            r_req.write_data     <= i_req.write_data;
            r_req.channel        <= i_req.channel;
            r_req.request_length <= i_req.request_length;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

    // Valid flags and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_base_addr[i] <= '0;
                r_base_cnt[i]  <= '0;
                r_cur_addr[i]  <= '0;
                r_cur_cnt[i]   <= '0;
                r_mode[i]      <= '0;
            end
            for (int j = 0; j < NUM_CHIP; j++) begin
                r_mask[j]   <= 4'hF;
                r_status[j] <= '0;
                r_tog[j]    <= 1'b0;
            end
        end else begin
            if (i_req.ready) begin
                r_req_vld <= i_req.valid;
            end
            if (adv) begin
                r_rsp_vld   <= 1'b1;
                r_base_addr <= n_base_addr;
                r_base_cnt  <= n_base_cnt;
                r_cur_addr  <= n_cur_addr;
                r_cur_cnt   <= n_cur_cnt;
                r_mode      <= n_mode;
                r_mask      <= n_mask;
                r_status    <= n_status;
                r_tog       <= n_tog;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // Outputs
    assign o_rsp.valid              = r_rsp_vld;
    assign o_rsp.read_data          = r_rsp.read_data;
    assign o_rsp.moved_count        = r_rsp.moved_count;
    assign o_rsp.start_address      = r_rsp.start_address;
    assign o_rsp.transfer_kind      = r_rsp.transfer_kind;
    assign o_rsp.address_decrements = r_rsp.address_decrements;
    assign o_rsp.element_bytes      = r_rsp.element_bytes;
    assign o_rsp.terminal_count     = r_rsp.terminal_count;

    // Checks
    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.transfer_kind == KIND_NONE) |->
        (o_rsp.moved_count == '0 && o_rsp.start_address == '0
         && !o_rsp.terminal_count && !o_rsp.address_decrements))
        else $error("refused or port result carries transfer fields");

    a_tc_needs_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.terminal_count) |-> (o_rsp.transfer_kind != KIND_NONE))
        else $error("terminal count without a transfer");

    a_elem_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.element_bytes == EB_BYTE || o_rsp.element_bytes == EB_WORD))
        else $error("element size out of range");

    a_req_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_req_vld)
        else $error("accepted request lost from input register");

    a_master_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_req.opcode == OP_PORT_WR && r_req.port == PORT_MRST0)
        |=> (r_mask[0] == 4'hF && !r_tog[0]))
        else $error("master reset did not mask first chip");

endmodule

// ===== verif/tb_dual_dma_controller_registers_core.sv =====
// ----------------------------------------------------------------------------
// tb_dual_dma_controller_registers_core
// Drives port writes, port reads and transfer requests into the cascaded DMA
// register pair and checks every result against a register mirror kept in
// the bench. It opens with a short directed pass over the corner cases. The
// random traffic that follows is mostly channel programming followed by
// bursts of transfers, with reads, control writes and raw noise mixed in.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_dual_dma_controller_registers_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ddmacr_pkg::*;

    localparam int ITEMS_TARGET = 1800;
    localparam int LIMIT_NS     = 4_000_000;
    localparam int DRAIN_GUARD  = 10000;

    // Undefined opcode: must leave state alone
    localparam logic [OPCODE_W-1:0] OP_UNDEF = 2'd3;

    // Address and count port windows
    localparam logic [PORT_W-1:0] ADDR_LAST0  = 11'h006;
    localparam logic [PORT_W-1:0] COUNT_LAST0 = 11'h007;
    localparam logic [PORT_W-1:0] ADDR_BASE1  = 11'h0C0;
    localparam logic [PORT_W-1:0] ADDR_LAST1  = 11'h0CC;
    localparam logic [PORT_W-1:0] COUNT_BASE1 = 11'h0C2;
    localparam logic [PORT_W-1:0] COUNT_LAST1 = 11'h0CE;
    localparam logic [PORT_W-1:0] PAGE_LO_BASE = 11'h080;
    localparam logic [PORT_W-1:0] PAGE_HI_BASE = 11'h480;

    // Page register offset per channel; channel 4 has none
    localparam int UNPAGED_CH = 4;
    localparam logic [3:0] PAGE_NIB [NUM_CH] =
        '{4'h7, 4'h3, 4'h1, 4'h2, 4'h0, 4'hB, 4'h9, 4'hA};

    // Mode byte fields
    localparam int MODE_DOWN = 5;
    localparam int MODE_AUTO = 4;
    localparam logic [1:0] OPMODE_CASCADE = 2'd3;
    localparam logic [1:0] TR_VERIFY      = 2'd0;
    localparam logic [1:0] TR_TO_MEM      = 2'd1;

    // Single mask command: bit 2 sets the mask
    localparam int SMASK_SET = 2;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   items_sent;

    ddmacr_req_if req_ch();
    ddmacr_rsp_if rsp_ch();

    dual_dma_controller_registers_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    function automatic logic [PORT_W-1:0] addr_port(int c);
        return (c < 4) ? PORT_W'(c * 2) : PORT_W'(ADDR_BASE1 + (c - 4) * 4);
    endfunction

    function automatic logic [PORT_W-1:0] count_port(int c);
        return (c < 4) ? PORT_W'(c * 2 + 1) : PORT_W'(COUNT_BASE1 + (c - 4) * 4);
    endfunction

    function automatic logic [7:0] mode_word(logic [1:0] opm, bit down, bit auto_init,
                                             logic [1:0] tr, logic [1:0] sel);
        return {opm, down, auto_init, tr, sel};
    endfunction

    // ------------------------------------------------------------------------
    // Register mirror: predicts each result and holds those still due
    // ------------------------------------------------------------------------
    class dma_pair_mirror;
        bit [BASE_W-1:0] base_addr [NUM_CH];
        bit [LEN_W-1:0]  base_cnt  [NUM_CH];
        bit [ADDR_W-1:0] cur_addr  [NUM_CH];
        bit [LEN_W-1:0]  cur_cnt   [NUM_CH];
        bit [7:0]        mode      [NUM_CH];
        bit [3:0]        mask      [NUM_CHIP];
        bit [7:0]        status    [NUM_CHIP];
        bit              flip      [NUM_CHIP];
        t_rsp            due_results [$];
        int              errors;

        function new();
            for (int c = 0; c < NUM_CH; c++) begin
                base_addr[c] = '0;
                base_cnt[c]  = '0;
                cur_addr[c]  = '0;
                cur_cnt[c]   = '0;
                mode[c]      = '0;
            end
            for (int k = 0; k < NUM_CHIP; k++) begin
                mask[k]   = 4'hF;
                status[k] = '0;
                flip[k]   = 1'b0;
            end
            errors = 0;
        endfunction

        function int addr_chan(logic [PORT_W-1:0] p);
            if (p <= ADDR_LAST0 && !p[0]) return int'(p >> 1);
            if (p >= ADDR_BASE1 && p <= ADDR_LAST1 && p[1:0] == 2'd0)
                return 4 + int'((p - ADDR_BASE1) >> 2);
            return -1;
        endfunction

        function int count_chan(logic [PORT_W-1:0] p);
            if (p <= COUNT_LAST0 && p[0]) return int'(p >> 1);
            if (p >= COUNT_BASE1 && p <= COUNT_LAST1 && p[1:0] == 2'd2)
                return 4 + int'((p - COUNT_BASE1) >> 2);
            return -1;
        endfunction

        function int page_chan(logic [3:0] nib);
            for (int c = 0; c < NUM_CH; c++)
                if (c != UNPAGED_CH && PAGE_NIB[c] == nib) return c;
            return -1;
        endfunction

        function void port_write(logic [PORT_W-1:0] p, logic [7:0] v);
            int ch;
            int chip;
            bit [7:0] b;
            ch = addr_chan(p);
            if (ch >= 0) begin
                chip = ch / 4;
                if (!flip[chip]) begin
                    base_addr[ch][7:0] = v;
                end else begin
                    base_addr[ch][15:8] = v;
                    cur_addr[ch] = ADDR_W'(base_addr[ch]);
                end
                flip[chip] ^= 1'b1;
                return;
            end
            ch = count_chan(p);
            if (ch >= 0) begin
                // count bytes are kept as written value plus one
                chip = ch / 4;
                b = v + 8'd1;
                if (!flip[chip]) begin
                    base_cnt[ch][7:0] = b;
                end else begin
                    base_cnt[ch][15:8] = b;
                    cur_cnt[ch] = base_cnt[ch];
                end
                flip[chip] ^= 1'b1;
                return;
            end
            if (p[PORT_W-1:4] == PAGE_LO_BLK) begin
                ch = page_chan(p[3:0]);
                if (ch >= 0) base_addr[ch][23:16] = v;
                return;
            end
            if (p[PORT_W-1:4] == PAGE_HI_BLK) begin
                ch = page_chan(p[3:0]);
                if (ch >= 0) base_addr[ch][27:24] = v[3:0];
                return;
            end
            case (p)
                PORT_MODE0:  mode[v[1:0]] = v;
                PORT_MODE1:  mode[4 + v[1:0]] = v;
                PORT_SMASK0: mask[0][v[1:0]] = v[SMASK_SET];
                PORT_SMASK1: mask[1][v[1:0]] = v[SMASK_SET];
                PORT_AMASK0: mask[0] = v[3:0];
                PORT_AMASK1: mask[1] = v[3:0];
                PORT_FFCLR0: flip[0] = 1'b0;
                PORT_FFCLR1: flip[1] = 1'b0;
                PORT_MRST0: begin
                    flip[0] = 1'b0;
                    mask[0] = 4'hF;
                end
                PORT_MRST1: begin
                    flip[1] = 1'b0;
                    mask[1] = 4'hF;
                end
                PORT_MCLR0:  mask[0] = '0;
                PORT_MCLR1:  mask[1] = '0;
                default: ;
            endcase
        endfunction

        function bit [7:0] port_read(logic [PORT_W-1:0] p);
            int ch;
            int chip;
            bit [7:0] r;
            ch = addr_chan(p);
            if (ch >= 0) begin
                chip = ch / 4;
                r = flip[chip] ? cur_addr[ch][15:8] : cur_addr[ch][7:0];
                flip[chip] ^= 1'b1;
                return r;
            end
            ch = count_chan(p);
            if (ch >= 0) begin
                chip = ch / 4;
                r = flip[chip] ? cur_cnt[ch][15:8] : cur_cnt[ch][7:0];
                flip[chip] ^= 1'b1;
                return r;
            end
            if (p[PORT_W-1:4] == PAGE_LO_BLK) begin
                ch = page_chan(p[3:0]);
                return (ch >= 0) ? base_addr[ch][23:16] : 8'd0;
            end
            if (p[PORT_W-1:4] == PAGE_HI_BLK) begin
                ch = page_chan(p[3:0]);
                return (ch >= 0) ? {4'd0, base_addr[ch][27:24]} : 8'd0;
            end
            if (p == PORT_STATUS0) return status[0];
            if (p == PORT_STATUS1) return status[1];
            return 8'd0;
        endfunction

        // Work out the result of one accepted request and queue it
        function void note_request(t_req r);
            t_rsp e;
            int c;
            int chip;
            bit [7:0] m;
            bit [LEN_W-1:0] n;
            bit [ADDR_W-1:0] step;
            e = '0;
            e.element_bytes = EB_BYTE;
            case (r.opcode)
                OP_PORT_WR: port_write(r.port, r.write_data);
                OP_PORT_RD: e.read_data = port_read(r.port);
                OP_XFER: begin
                    c = int'(r.channel);
                    chip = c / 4;
                    m = mode[c];
                    e.element_bytes = (c < 4) ? EB_BYTE : EB_WORD;
                    // refused when masked, not single mode, or illegal type
                    if (!mask[chip][c % 4] && m[7:6] == OPMODE_SINGLE &&
                        m[3:2] != TRMODE_ILLEGAL) begin
                        n = (cur_cnt[c] < r.request_length) ? cur_cnt[c]
                                                           : r.request_length;
                        step = ADDR_W'(n);
                        if (c >= 4) step = step << 1;
                        e.start_address = cur_addr[c];
                        cur_cnt[c] = cur_cnt[c] - n;
                        cur_addr[c] = m[MODE_DOWN] ? cur_addr[c] - step
                                                   : cur_addr[c] + step;
                        e.moved_count = n;
                        e.transfer_kind = m[3:2] + 2'd1;
                        e.address_decrements = m[MODE_DOWN];
                        // an empty count also lands here
                        if (cur_cnt[c] == '0) begin
                            e.terminal_count = 1'b1;
                            status[chip][c % 4] = 1'b1;
                            status[chip][c % 4 + 4] = 1'b0;
                            if (m[MODE_AUTO]) begin
                                cur_addr[c] = ADDR_W'(base_addr[c]);
                                cur_cnt[c] = base_cnt[c];
                            end
                        end
                    end
                end
                default: ;
            endcase
            due_results.push_back(e);
        endfunction

        function void flag(string what, t_rsp want, t_rsp got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: exp rd=%h mv=%h sa=%h k=%0d dn=%0b eb=%0d tc=%0b",
                         $time, what, want.read_data, want.moved_count,
                         want.start_address, want.transfer_kind,
                         want.address_decrements, want.element_bytes,
                         want.terminal_count);
            if (errors <= 10)
                $display("    got rd=%h mv=%h sa=%h k=%0d dn=%0b eb=%0d tc=%0b",
                         got.read_data, got.moved_count, got.start_address,
                         got.transfer_kind, got.address_decrements,
                         got.element_bytes, got.terminal_count);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (due_results.size() == 0) begin
                flag("result with no request due", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.read_data !== want.read_data ||
                got.moved_count !== want.moved_count ||
                got.start_address !== want.start_address ||
                got.transfer_kind !== want.transfer_kind ||
                got.address_decrements !== want.address_decrements ||
                got.element_bytes !== want.element_bytes ||
                got.terminal_count !== want.terminal_count)
                flag("result mismatch", want, got);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void drain_leftovers();
            while (due_results.size() != 0)
                flag("result never returned", due_results.pop_front(), '0);
        endfunction
    endclass

    dma_pair_mirror mirror;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls except during the quiet stretch
    always @(posedge i_clk) begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 24);
    end

    // Result monitor
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.read_data          = rsp_ch.read_data;
            got.moved_count        = rsp_ch.moved_count;
            got.start_address      = rsp_ch.start_address;
            got.transfer_kind      = rsp_ch.transfer_kind;
            got.address_decrements = rsp_ch.address_decrements;
            got.element_bytes      = rsp_ch.element_bytes;
            got.terminal_count     = rsp_ch.terminal_count;
            mirror.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------
    task automatic send(t_req r);
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= r.opcode;
        req_ch.port           <= r.port;
        req_ch.write_data     <= r.write_data;
        req_ch.channel        <= r.channel;
        req_ch.request_length <= r.request_length;
        do @(posedge i_clk); while (!req_ch.ready);
        mirror.note_request(r);
        items_sent++;
        if (!no_idle && $urandom_range(0, 99) < 24) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic port_wr(logic [PORT_W-1:0] p, logic [7:0] d);
        t_req r;
        r.opcode         = OP_PORT_WR;
        r.port           = p;
        r.write_data     = d;
        r.channel        = CH_W'($urandom);
        r.request_length = LEN_W'($urandom);
        send(r);
    endtask

    task automatic port_rd(logic [PORT_W-1:0] p);
        t_req r;
        r.opcode         = OP_PORT_RD;
        r.port           = p;
        r.write_data     = DATA_W'($urandom);
        r.channel        = CH_W'($urandom);
        r.request_length = LEN_W'($urandom);
        send(r);
    endtask

    task automatic xfer(int c, logic [LEN_W-1:0] len);
        t_req r;
        r.opcode         = OP_XFER;
        r.port           = PORT_W'($urandom);
        r.write_data     = DATA_W'($urandom);
        r.channel        = CH_W'(c);
        r.request_length = len;
        send(r);
    endtask

    // Hold requests back until every due result is in
    task automatic wait_drained();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (mirror.outstanding() != 0 && guard < DRAIN_GUARD);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_req raw;
        int focus;
        int ch;
        int pick;
        int sel;
        bit paused;
        logic [7:0] d;
        logic [1:0] opm;
        logic [1:0] tr;
        logic [LEN_W-1:0] len;

        mirror = new();
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        items_sent = 0;
        paused = 1'b0;
        focus = 0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_PORT_WR;
        req_ch.port = '0;
        req_ch.write_data = '0;
        req_ch.channel = '0;
        req_ch.request_length = '0;
        rsp_ch.ready = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, unmapped ports, undefined opcode
        port_rd(PORT_STATUS0);
        xfer(0, '1);
        xfer(7, '1);
        raw = '1;
        raw.opcode = OP_UNDEF;
        send(raw);
        port_wr('1, '1);
        port_rd('1);
        port_rd(PORT_MRST1);
        port_wr(PORT_STATUS1, '1);

        // Directed: channel 5 with all-ones address and an empty count
        port_wr(PORT_FFCLR1, '0);
        port_wr(addr_port(5), '1);
        port_wr(addr_port(5), '1);
        port_wr(count_port(5), '1);
        port_wr(count_port(5), '1);
        port_wr(PAGE_LO_BASE | PAGE_NIB[5], '1);
        port_wr(PAGE_HI_BASE | PAGE_NIB[5], '1);
        port_wr(PORT_MODE1, mode_word(OPMODE_SINGLE, 1'b1, 1'b1, TR_TO_MEM, 2'd1));
        port_wr(PORT_SMASK1, 8'd1);
        xfer(5, '0);
        port_rd(PORT_STATUS1);
        port_rd(addr_port(5));
        port_rd(addr_port(5));

        // Directed: refusals for cascade mode and the illegal transfer type
        port_wr(PORT_AMASK0, '0);
        port_wr(PORT_MODE0, mode_word(OPMODE_CASCADE, 1'b0, 1'b0, TR_VERIFY, 2'd0));
        xfer(0, 16'd1);
        port_wr(PORT_MODE0, mode_word(OPMODE_SINGLE, 1'b0, 1'b0, TRMODE_ILLEGAL, 2'd0));
        xfer(0, 16'd1);
        port_wr(PORT_MRST0, '1);

        // Random traffic
        while (items_sent < ITEMS_TARGET) begin
            no_idle = (items_sent >= 500 && items_sent < 800);
            if (!paused && items_sent >= 1000) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // program one channel from scratch
                ch = $urandom_range(0, NUM_CH - 1);
                port_wr((ch < 4) ? PORT_FFCLR0 : PORT_FFCLR1, DATA_W'($urandom));
                port_wr(addr_port(ch), DATA_W'($urandom));
                port_wr(addr_port(ch), DATA_W'($urandom));
                d = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom)
                                                : DATA_W'($urandom_range(0, 40));
                port_wr(count_port(ch), d);
                d = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : 8'hFF;
                port_wr(count_port(ch), d);
                port_wr(PAGE_LO_BASE | PAGE_NIB[ch], DATA_W'($urandom));
                port_wr(PAGE_HI_BASE | PAGE_NIB[ch], DATA_W'($urandom));
                opm = ($urandom_range(0, 9) == 0) ? 2'($urandom) : OPMODE_SINGLE;
                tr = ($urandom_range(0, 9) == 0) ? TRMODE_ILLEGAL
                                                 : 2'($urandom_range(0, 2));
                port_wr((ch < 4) ? PORT_MODE0 : PORT_MODE1,
                        mode_word(opm, 1'($urandom), 1'($urandom), tr, 2'(ch)));
                d = DATA_W'($urandom);
                d[SMASK_SET] = 1'b0;
                d[1:0] = 2'(ch);
                port_wr((ch < 4) ? PORT_SMASK0 : PORT_SMASK1, d);
                focus = ch;
            end else if (pick < 60) begin
                // burst of transfers, mostly on the channel just set up
                repeat ($urandom_range(1, 6)) begin
                    ch = ($urandom_range(0, 4) != 0) ? focus
                                                     : $urandom_range(0, NUM_CH - 1);
                    sel = $urandom_range(0, 9);
                    if (sel < 6)       len = LEN_W'($urandom_range(0, 24));
                    else if (sel < 8)  len = LEN_W'($urandom_range(0, 300));
                    else if (sel == 8) len = '0;
                    else               len = LEN_W'($urandom);
                    xfer(ch, len);
                end
            end else if (pick < 78) begin
                // register read-back
                ch = $urandom_range(0, NUM_CH - 1);
                case ($urandom_range(0, 4))
                    0: begin
                        port_rd(addr_port(ch));
                        port_rd(addr_port(ch));
                    end
                    1: begin
                        port_rd(count_port(ch));
                        port_rd(count_port(ch));
                    end
                    2: port_rd(($urandom_range(0, 1) == 0) ? PORT_STATUS0 : PORT_STATUS1);
                    3: port_rd(PAGE_LO_BASE | PAGE_NIB[ch]);
                    default: port_rd(PAGE_HI_BASE | PAGE_NIB[ch]);
                endcase
            end else if (pick < 88) begin
                // control writes with random content
                sel = $urandom_range(0, 1);
                d = DATA_W'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2: port_wr(sel ? PORT_MODE1 : PORT_MODE0, d);
                    3, 4:    port_wr(sel ? PORT_SMASK1 : PORT_SMASK0, d);
                    5:       port_wr(sel ? PORT_AMASK1 : PORT_AMASK0, d);
                    6:       port_wr(sel ? PORT_FFCLR1 : PORT_FFCLR0, d);
                    7:       port_wr(sel ? PORT_MCLR1 : PORT_MCLR0, d);
                    8:       port_wr(sel ? PORT_MRST1 : PORT_MRST0, d);
                    default: port_rd(sel ? PORT_MRST1 : PORT_MRST0);
                endcase
            end else begin
                // raw noise over every field
                raw.opcode = ($urandom_range(0, 19) == 0) ? OP_UNDEF
                                                          : 2'($urandom_range(0, 2));
                raw.port = PORT_W'($urandom);
                raw.write_data = DATA_W'($urandom);
                raw.channel = CH_W'($urandom);
                raw.request_length = LEN_W'($urandom);
                send(raw);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        mirror.drain_leftovers();
        if (mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ddmacr_pkg.sv
rtl/core/ddmacr_req_if.sv
rtl/core/ddmacr_rsp_if.sv
rtl/core/dual_dma_controller_registers_core.sv
verif/tb_dual_dma_controller_registers_core.sv
